// ----- hdl/sparse_range_address_translator_core_macros.svh -----
// Assertion macros shared by the range translator modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SPARSE_RANGE_ADDRESS_TRANSLATOR_CORE_MACROS_SVH
`define SPARSE_RANGE_ADDRESS_TRANSLATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Clocked property, disabled while reset is asserted.
`define SRAT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked during reset too.
`define SRAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/srat_pkg.sv -----
// Types and constants of the sparse range address translator.
// No dependencies; used by srat_ctrl, srat_dp and the top level.
package srat_pkg;

	localparam int MAX_RANGES_DEF = 1024;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 36;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 2'd2;

	// Mount modes
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_TABLE = 2'd1;
	localparam logic [1:0] MODE_FLAT  = 2'd2;

	// Commands of an input transaction
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_DATA    = 2'd0;
	localparam logic [1:0] ST_ZERO    = 2'd1;
	localparam logic [1:0] ST_NOMOUNT = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [9:0]  entry_index;
		logic [35:0] range_start;
		logic [31:0] range_length;
		logic [31:0] payload_position;
		logic [35:0] request_offset;
		logic [31:0] request_length;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [36:0] source_address;
		logic [31:0] take_length;
	} rsp_t;

	typedef struct packed {
		logic [35:0] start;
		logic [31:0] len;
		logic [31:0] pos;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic wr_en;
		logic take_req;
		logic rd_en;
		logic capture;
		logic miss;
		logic calc;
		logic emit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0]  mount_mode;
		logic [10:0] range_count;
		logic        chk_valid;
		logic        hit;
		logic        out_free;
	} ctl_sts_t;

endpackage

// ----- hdl/srat_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module srat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/srat_ctrl.sv -----
// Controller of the range translator: accepts transactions and sequences the table scan.
// Depends on srat_pkg and the assertion macro header.
`include "sparse_range_address_translator_core_macros.svh"
module srat_ctrl #(
	parameter int MAX_RANGES = srat_pkg::MAX_RANGES_DEF,
	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
	localparam int CW = $clog2(MAX_RANGES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_cmd,
	output logic               req_stall,
	input  srat_pkg::ctl_sts_t sts,
	output srat_pkg::ctl_cmd_t cmd,
	output logic [AW-1:0]      rd_addr
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_CALC = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] lim;
	logic [31:0]   rc_w, lim_w;

	// Search stops at the table depth even if the count register is larger
	always_comb begin
		rc_w  = 32'(sts.range_count);
		lim_w = (rc_w > 32'(MAX_RANGES)) ? 32'(MAX_RANGES) : rc_w;
		lim   = lim_w[CW-1:0];
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_cmd == srat_pkg::CMD_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.take_req = 1'b1;
						if (sts.mount_mode == srat_pkg::MODE_TABLE) begin
							state_d = S_SCAN;
							idx_d   = '0;
						end else begin
							state_d = S_CALC;
						end
					end
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.capture = 1'b1;
					state_d     = S_CALC;
				end else if (idx_q < lim) begin
					cmd.rd_en = 1'b1;
					idx_d     = idx_q + CW'(1);
				end else if (!sts.chk_valid) begin
					// all entries checked, none covers the offset
					cmd.miss = 1'b1;
					state_d  = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rd_addr   = idx_q[AW-1:0];

	`SRAT_ASSERT(a_rd_only_in_scan, clk, arst_n, cmd.rd_en |-> state_q == S_SCAN, "table read outside scan")
	`SRAT_ASSERT(a_lookup_leaves_idle, clk, arst_n, (req_valid && !req_stall && req_cmd == srat_pkg::CMD_LOOKUP) |=> (state_q == S_SCAN || state_q == S_CALC), "lookup transaction not started")

endmodule

// ----- hdl/srat_dp.sv -----
// Datapath of the range translator: configuration registers, range table, compare and
// result arithmetic, output register. Depends on srat_pkg, srat_ram and the macro header.
`include "sparse_range_address_translator_core_macros.svh"
module srat_dp #(
	parameter int MAX_RANGES = srat_pkg::MAX_RANGES_DEF,
	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srat_pkg::req_t                      req_item,
	input  logic                                cfg_valid,
	input  logic [srat_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srat_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  srat_pkg::ctl_cmd_t                  cmd,
	input  logic [AW-1:0]                       rd_addr,
	output srat_pkg::ctl_sts_t                  sts,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output srat_pkg::rsp_t                      rsp_item
);

	logic [1:0]  mount_mode_q;
	logic [10:0] range_count_q;
	logic [35:0] image_size_q;

	logic [35:0] off_q;
	logic [31:0] len_q;

	logic [31:0]      widx;
	logic             wr_ok;
	srat_pkg::entry_t wr_ent, rd_ent;
	logic             chk_s1;
	logic [36:0]      ent_end;
	logic             hit;

	logic        found_q;
	logic [35:0] hit_start_q;
	logic [31:0] hit_len_q;
	logic [31:0] hit_pos_q;
	logic [35:0] within_q;
	logic        flat_in_q;
	logic [35:0] rem_q;

	logic [31:0]    tab_room, tab_take, flat_take;
	logic [36:0]    tab_addr;
	srat_pkg::rsp_t res;
	logic           rsp_valid_q;
	srat_pkg::rsp_t rsp_q;
	logic           out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_mode_q  <= srat_pkg::MODE_NONE;
			range_count_q <= '0;
			image_size_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				srat_pkg::REG_MOUNT_MODE:  mount_mode_q  <= cfg_data[1:0];
				srat_pkg::REG_RANGE_COUNT: range_count_q <= cfg_data[10:0];
				srat_pkg::REG_IMAGE_SIZE:  image_size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			off_q <= req_item.request_offset;
			len_q <= req_item.request_length;
		end
	end

	// Drop loads aimed past the table depth
	always_comb begin
		widx         = 32'(req_item.entry_index);
		wr_ok        = cmd.wr_en && (widx < 32'(MAX_RANGES));
		wr_ent.start = req_item.range_start;
		wr_ent.len   = req_item.range_length;
		wr_ent.pos   = req_item.payload_position;
	end

	srat_ram #(
		.WIDTH($bits(srat_pkg::entry_t)),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (wr_ok),
		.waddr(widx[AW-1:0]),
		.wdata(wr_ent),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rd_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= cmd.rd_en;
		end
	end

	always_comb begin
		ent_end = {1'b0, rd_ent.start} + {5'd0, rd_ent.len};
		hit     = chk_s1 && (off_q >= rd_ent.start) && ({1'b0, off_q} < ent_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			found_q <= 1'b1;
		end else if (cmd.miss) begin
			found_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hit_start_q <= rd_ent.start;
			hit_len_q   <= rd_ent.len;
			hit_pos_q   <= rd_ent.pos;
		end
		if (cmd.calc) begin
			within_q  <= off_q - hit_start_q;
			flat_in_q <= off_q < image_size_q;
			rem_q     <= image_size_q - off_q;
		end
	end

	// within is below the entry length, so the room fits 32 bits
	always_comb begin
		tab_room  = hit_len_q - within_q[31:0];
		tab_take  = (tab_room < len_q) ? tab_room : len_q;
		tab_addr  = 37'({range_count_q, 4'b1000}) + 37'(hit_pos_q) + 37'(within_q);
		flat_take = (rem_q < {4'd0, len_q}) ? rem_q[31:0] : len_q;
		res       = '0;
		case (mount_mode_q)
			srat_pkg::MODE_TABLE: begin
				if (found_q) begin
					res.status         = srat_pkg::ST_DATA;
					res.source_address = tab_addr;
					res.take_length    = tab_take;
				end else begin
					res.status = srat_pkg::ST_ZERO;
				end
			end
			srat_pkg::MODE_FLAT: begin
				if (flat_in_q) begin
					res.status         = srat_pkg::ST_DATA;
					res.source_address = 37'(off_q);
					res.take_length    = flat_take;
				end else begin
					res.status = srat_pkg::ST_ZERO;
				end
			end
			default: begin
				res.status = srat_pkg::ST_NOMOUNT;
			end
		endcase
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= res;
		end
	end

	always_comb begin
		sts.mount_mode  = mount_mode_q;
		sts.range_count = range_count_q;
		sts.chk_valid   = chk_s1;
		sts.hit         = hit;
		sts.out_free    = out_free;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	`SRAT_ASSERT(a_emit_no_overwrite, clk, arst_n, cmd.emit |-> (!rsp_valid_q || !rsp_stall), "pending result overwritten")

endmodule

// ----- hdl/sparse_range_address_translator_core.sv -----
// Sparse range address translator, top level: controller, datapath and ports.
// Depends on srat_pkg, srat_ctrl, srat_dp (and srat_ram below it).
//
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes mount_mode,
//   range_count and image_size; cfg_ready is always high. Write only while idle.
//   Request channel (req_valid/req_stall, req_item) takes a load or a lookup transaction.
//   A load writes one table slot and produces no response; loads past the table depth are dropped.
//   A lookup produces one response on rsp_valid/rsp_stall, rsp_item.
// Lookup flow:
//   Table mode: the table RAM is read one entry per cycle until the first covering
//   entry, with at most min(range_count, MAX_RANGES) reads. A hit captures the entry;
//   a miss is declared once every read entry has been checked, at once with a zero
//   count. Both then pass the calculate and emit states. Flat and unmounted lookups
//   go straight to those two states. The emit state waits for a free output register.
//   One lookup is in flight at a time; req_stall is high until its result is registered,
//   so the next request can be accepted in the cycle in which that result is shown.
// Reset: arst_n clears the control state and the configuration registers (to unmounted);
//   table contents are undefined until loaded, no clearing pass is run.
// Stall: a pending response holds in the output register while rsp_stall is high; the
//   next request is still accepted, and its result waits until that register frees up.
module sparse_range_address_translator_core #(
	parameter int MAX_RANGES = srat_pkg::MAX_RANGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srat_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  srat_pkg::req_t                  req_item,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output srat_pkg::rsp_t                  rsp_item
);

	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

	srat_pkg::ctl_cmd_t cmd;
	srat_pkg::ctl_sts_t sts;
	logic [AW-1:0]      rd_addr;

	assign cfg_ready = 1'b1;

	srat_ctrl #(
		.MAX_RANGES(MAX_RANGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_cmd  (req_item.cmd),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	srat_dp #(
		.MAX_RANGES(MAX_RANGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_item (req_item),
		.cfg_valid(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

endmodule
